// File: rtl/pulse_rate_and_width_histogram_defines.svh
// assertion helpers shared by the rtl
`ifndef PULSE_RATE_AND_WIDTH_HISTOGRAM_DEFINES_SVH
`define PULSE_RATE_AND_WIDTH_HISTOGRAM_DEFINES_SVH

// condition that holds at every edge out of reset
`define PRH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define PRH_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/prh_pkg.sv
package prh_pkg;

  localparam int HIST_BINS_DEF  = 128;
  localparam int RING_SLOTS_DEF = 64;

  localparam logic [31:0] GAP_LIMIT_MS  = 32'd100000;
  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
  localparam int          WIDTH_SHIFT   = 2;
  localparam logic [15:0] INTEG_RESET   = 16'd1000;

  localparam logic [2:0] ACT_PULSE = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_CLEAR = 3'd2;
  localparam logic [2:0] ACT_READ  = 3'd3;
  localparam logic [2:0] ACT_RATE  = 3'd4;

  localparam logic REG_INTEG = 1'b0;

endpackage

// File: rtl/prh_ram.sv
module prh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/prh_div.sv
module prh_div #(
  parameter int NW = 38,
  parameter int DW = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_q[DW-1:0], quo_q[NW-1]};
    diff    = shifted - {1'b0, den_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = diff[DW] ? shifted : diff;
      quo_d = {quo_q[NW-2:0], ~diff[DW]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[DW-1:0];

endmodule

// File: rtl/pulse_rate_and_width_histogram.sv
// operation: a pulse waits for the divider, then closes slots (at most RING_SLOTS + 1) and
//   counts the pulse in its bin; a long gap first zeroes the whole ring; a rate read
//   multiplies, then divides (divider yields one quotient bit per cycle); a bin read reads
//   the RAM; clear sweeps every bin; start and unknown actions go straight to the result
// flow: one transaction at a time, next input accepted in the cycle after the result is registered
// reset: control state clears at once, then a sweep zeroes every histogram bin, taking no input
`include "pulse_rate_and_width_histogram_defines.svh"

module pulse_rate_and_width_histogram #(
  parameter int HIST_BINS  = prh_pkg::HIST_BINS_DEF,
  parameter int RING_SLOTS = prh_pkg::RING_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] time_ms_i,
  input  logic [15:0] pulse_width_us_i,
  input  logic [6:0]  bin_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] bin_count_o,
  output logic [31:0] counts_per_minute_o,
  output logic [6:0]  valid_slots_o
);
  import prh_pkg::*;

  localparam int HB_AW  = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
  localparam int RS_AW  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int FILL_W = $clog2(RING_SLOTS + 1);
  localparam int SUM_W  = 16 + FILL_W;
  localparam int NUM_W  = SUM_W + 16;
  localparam int DEN_W  = 16 + FILL_W;
  localparam int PCNT_W = $clog2(RING_SLOTS + 2);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ELAP  = 4'd2;
  localparam logic [3:0] S_RZERO = 4'd3;
  localparam logic [3:0] S_DIVGO = 4'd4;
  localparam logic [3:0] S_DIVW  = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PWR   = 4'd7;
  localparam logic [3:0] S_HRD   = 4'd8;
  localparam logic [3:0] S_HWR   = 4'd9;
  localparam logic [3:0] S_HCLR  = 4'd10;
  localparam logic [3:0] S_BRD   = 4'd11;
  localparam logic [3:0] S_BCAP  = 4'd12;
  localparam logic [3:0] S_MUL   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]        state_q, state_d;
  logic [15:0]       integ_q, integ_d;
  logic [RS_AW-1:0]  pos_q, pos_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [15:0]       cur_q, cur_d;
  logic [31:0]       start_q, start_d;
  logic              out_valid_q, out_valid_d;
  logic [15:0]       obin_q, obin_d;
  logic [31:0]       ocpm_q, ocpm_d;
  logic [6:0]        oslots_q, oslots_d;

  logic [2:0]        act_q, act_d;
  logic [31:0]       time_q, time_d;
  logic [15:0]       width_q, width_d;
  logic [6:0]        idx_q, idx_d;
  logic [16:0]       elapsed_q, elapsed_d;
  logic [15:0]       bin_q, bin_d;
  logic [31:0]       cpm_q, cpm_d;
  logic [15:0]       pv_q, pv_d;
  logic [PCNT_W-1:0] pcnt_q, pcnt_d;
  logic [HB_AW-1:0]  hcnt_q, hcnt_d;
  logic [RS_AW-1:0]  zcnt_q, zcnt_d;
  logic [NUM_W-1:0]  prod_q, prod_d;
  logic [DEN_W-1:0]  den_q, den_d;

  logic [15:0]       len;
  logic [31:0]       elapsed_w;
  logic [13:0]       bin_w;
  logic [HB_AW-1:0]  hbin;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [DEN_W-1:0]  div_rem;
  logic              ring_we;
  logic [RS_AW-1:0]  ring_waddr;
  logic [15:0]       ring_wdata;
  logic [15:0]       ring_rdata;
  logic              hist_we;
  logic [HB_AW-1:0]  hist_waddr;
  logic [15:0]       hist_wdata;
  logic [HB_AW-1:0]  hist_raddr;
  logic [15:0]       hist_rdata;
  logic              cfg_wr;

  assign len       = (integ_q == '0) ? 16'd1 : integ_q;
  assign elapsed_w = time_q - start_q;
  assign bin_w     = width_q[15:WIDTH_SHIFT];
  assign hbin      = (bin_w >= 14'(HIST_BINS)) ? HB_AW'(HIST_BINS - 1) : HB_AW'(bin_w);

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_INTEG);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_INTEG) ? {16'b0, integ_q} : 32'b0;
  assign integ_d = cfg_wr ? pwdata[15:0] : integ_q;

  assign div_start = (state_q == S_DIVGO);
  assign div_num   = (act_q == ACT_PULSE) ? NUM_W'(elapsed_q) : prod_q;
  assign div_den   = (act_q == ACT_PULSE) ? DEN_W'(len) : den_q;

  assign hist_raddr = (state_q == S_BRD) ? HB_AW'(idx_q) : hbin;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    cur_d       = cur_q;
    start_d     = start_q;
    out_valid_d = out_valid_q;
    obin_d      = obin_q;
    ocpm_d      = ocpm_q;
    oslots_d    = oslots_q;
    act_d       = act_q;
    time_d      = time_q;
    width_d     = width_q;
    idx_d       = idx_q;
    elapsed_d   = elapsed_q;
    bin_d       = bin_q;
    cpm_d       = cpm_q;
    pv_d        = pv_q;
    pcnt_d      = pcnt_q;
    hcnt_d      = hcnt_q;
    zcnt_d      = zcnt_q;
    prod_d      = prod_q;
    den_d       = den_q;
    ring_we     = 1'b0;
    ring_waddr  = pos_q;
    ring_wdata  = pv_q;
    hist_we     = 1'b0;
    hist_waddr  = hbin;
    hist_wdata  = (hist_rdata == 16'hFFFF) ? hist_rdata : hist_rdata + 16'd1;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT, S_HCLR: begin
        hist_we    = 1'b1;
        hist_waddr = hcnt_q;
        hist_wdata = '0;
        hcnt_d     = hcnt_q + 1'b1;
        if (hcnt_q == HB_AW'(HIST_BINS - 1)) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          time_d  = time_ms_i;
          width_d = pulse_width_us_i;
          idx_d   = bin_index_i;
          bin_d   = '0;
          cpm_d   = '0;
          hcnt_d  = '0;
          case (action_i)
            ACT_PULSE: state_d = S_ELAP;
            ACT_START: begin
              cur_d   = '0;
              start_d = time_ms_i;
              state_d = S_DONE;
            end
            ACT_CLEAR: state_d = S_HCLR;
            ACT_READ:  state_d = (32'(bin_index_i) < HIST_BINS) ? S_BRD : S_DONE;
            ACT_RATE:  state_d = (fill_q == '0) ? S_DONE : S_MUL;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_ELAP: begin
        if (elapsed_w > GAP_LIMIT_MS) begin
          // long gap: zero the ring, keep fill and write position
          sum_d     = '0;
          start_d   = time_q;
          elapsed_d = '0;
          zcnt_d    = '0;
          state_d   = S_RZERO;
        end else begin
          elapsed_d = elapsed_w[16:0];
          state_d   = S_DIVGO;
        end
      end
      S_RZERO: begin
        ring_we    = 1'b1;
        ring_waddr = zcnt_q;
        ring_wdata = '0;
        zcnt_d     = zcnt_q + 1'b1;
        if (zcnt_q == RS_AW'(RING_SLOTS - 1)) begin
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: state_d = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          if (act_q == ACT_PULSE) begin
            // n*len equals elapsed minus remainder
            start_d = start_q + 32'(elapsed_q) - 32'(div_rem[15:0]);
            if (div_quo == '0) begin
              state_d = S_HRD;
            end else begin
              pv_d    = cur_q;
              cur_d   = '0;
              pcnt_d  = (div_quo > NUM_W'(RING_SLOTS + 1)) ?
                        PCNT_W'(RING_SLOTS + 1) : PCNT_W'(div_quo);
              state_d = S_PRD;
            end
          end else begin
            cpm_d   = (|div_quo[NUM_W-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
            state_d = S_DONE;
          end
        end
      end
      S_PRD: state_d = S_PWR;
      S_PWR: begin
        ring_we = 1'b1;
        if (fill_q == FILL_W'(RING_SLOTS)) begin
          sum_d = sum_q - SUM_W'(ring_rdata) + SUM_W'(pv_q);
        end else begin
          fill_d = fill_q + 1'b1;
          sum_d  = sum_q + SUM_W'(pv_q);
        end
        pos_d  = (pos_q == RS_AW'(RING_SLOTS - 1)) ? '0 : pos_q + 1'b1;
        pv_d   = '0;
        pcnt_d = pcnt_q - 1'b1;
        state_d = (pcnt_q == PCNT_W'(1)) ? S_HRD : S_PRD;
      end
      S_HRD: begin
        if (cur_q != 16'hFFFF) begin
          cur_d = cur_q + 16'd1;
        end
        state_d = S_HWR;
      end
      S_HWR: begin
        hist_we = 1'b1;
        state_d = S_DONE;
      end
      S_BRD:  state_d = S_BCAP;
      S_BCAP: begin
        bin_d   = hist_rdata;
        state_d = S_DONE;
      end
      S_MUL: begin
        prod_d  = NUM_W'(sum_q) * NUM_W'(MS_PER_MINUTE);
        den_d   = DEN_W'(len) * DEN_W'(fill_q);
        state_d = S_DIVGO;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          obin_d      = bin_q;
          ocpm_d      = cpm_q;
          oslots_d    = 7'(fill_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      integ_q     <= INTEG_RESET;
      pos_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      cur_q       <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
      hcnt_q      <= '0;
      zcnt_q      <= '0;
      pcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      integ_q     <= integ_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      cur_q       <= cur_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      hcnt_q      <= hcnt_d;
      zcnt_q      <= zcnt_d;
      pcnt_q      <= pcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obin_q    <= obin_d;
    ocpm_q    <= ocpm_d;
    oslots_q  <= oslots_d;
    act_q     <= act_d;
    time_q    <= time_d;
    width_q   <= width_d;
    idx_q     <= idx_d;
    elapsed_q <= elapsed_d;
    bin_q     <= bin_d;
    cpm_q     <= cpm_d;
    pv_q      <= pv_d;
    prod_q    <= prod_d;
    den_q     <= den_d;
  end

  prh_div #(
    .NW(NUM_W),
    .DW(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  prh_ram #(
    .WIDTH(16),
    .DEPTH(RING_SLOTS),
    .AW   (RS_AW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(ring_wdata),
    .raddr_i(pos_q),
    .rdata_o(ring_rdata)
  );

  prh_ram #(
    .WIDTH(16),
    .DEPTH(HIST_BINS),
    .AW   (HB_AW)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  assign in_ready_o          = (state_q == S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign bin_count_o         = obin_q;
  assign counts_per_minute_o = ocpm_q;
  assign valid_slots_o       = oslots_q;

  `PRH_ASSERT(a_fill_bound, fill_q <= FILL_W'(RING_SLOTS), "ring fill beyond depth")
  `PRH_ASSERT(a_pos_bound, 32'(pos_q) < RING_SLOTS, "ring position beyond depth")
  `PRH_ASSERT(a_sum_empty, (fill_q != '0) || (sum_q == '0), "ring sum nonzero while empty")
  `PRH_ASSERT(a_div_den, !div_start || (div_den != '0), "divider started with zero divisor")
  `PRH_ASSERT_NEXT(a_done_out,
                   (state_q == S_DONE) && (!out_valid_q || out_ready_i),
                   out_valid_q, "result not presented")

endmodule
